// ----- rtl/tilt_packet_to_drive_decoder_core_defines.svh -----
// Assertion macros for the tilt packet to drive decoder
`ifndef TILT_PACKET_TO_DRIVE_DECODER_CORE_DEFINES_SVH
`define TILT_PACKET_TO_DRIVE_DECODER_CORE_DEFINES_SVH

// Check an implication on every rising clock edge outside reset
`define TPD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check an implication whose consequent must hold in the next cycle
`define TPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/tpd_pkg.sv -----
// Shared constants, types and helpers for the tilt packet to drive decoder
`timescale 1ns / 1ps
package tpd_pkg;

  localparam logic [1:0] CmdByte = 2'd0;
  localparam logic [1:0] CmdTick = 2'd1;
  localparam logic [1:0] CmdDist = 2'd2;
  localparam logic [1:0] CmdNone = 2'd3;

  localparam logic [7:0] HdrStart = 8'h21;
  localparam logic [7:0] HdrKind  = 8'h41;

  localparam logic [3:0] PosStart = 4'd0;
  localparam logic [3:0] PosKind  = 4'd1;
  localparam logic [3:0] PosData  = 4'd2;
  localparam logic [3:0] PosCheck = 4'd14;

  localparam logic [1:0] RegTimeout   = 2'd0;
  localparam logic [1:0] RegObstacle  = 2'd1;
  localparam logic [1:0] RegThreshold = 2'd2;

  localparam logic [31:0] TimeoutReset   = 32'd5000;
  localparam logic [15:0] ObstacleReset  = 16'd200;
  localparam logic [30:0] ThresholdReset = 31'h3F000000;

  localparam logic [1:0] DrvFwd  = 2'b01;
  localparam logic [1:0] DrvStop = 2'b00;
  localparam logic [1:0] DrvRev  = 2'b11;

  typedef struct packed {
    logic       checksum_error;
    logic       frame_accepted;
    logic [1:0] left_drive;
    logic [1:0] right_drive;
    logic       drive_update;
  } result_t;

  function automatic logic is_nan(input logic [31:0] v);
    return v[30:0] > 31'h7F800000;
  endfunction

  // a <= b in sign/magnitude order with -0 == +0, false on NaN
  function automatic logic f_le(input logic [31:0] a, input logic [31:0] b);
    logic az, bz, r;
    az = (a[30:0] == '0);
    bz = (b[30:0] == '0);
    if (az && bz) r = 1'b1;
    else if (a[31] && !b[31]) r = 1'b1;
    else if (!a[31] && b[31]) r = az && bz;
    else if (a[31]) r = a[30:0] >= b[30:0];
    else r = a[30:0] <= b[30:0];
    return r && !is_nan(a) && !is_nan(b);
  endfunction

endpackage

// ----- rtl/tilt_packet_to_drive_decoder_core.sv -----
// Top level of the tilt packet to drive decoder
`timescale 1ns / 1ps
`include "tilt_packet_to_drive_decoder_core_defines.svh"
// Takes one item per cycle while s_axis_tready is high: serial bytes, 1 ms ticks or distance
// readings, and returns one result for each through the output register. A frame is '!', 'A',
// x, y, z (little-endian IEEE singles) and an inverted-sum checksum; a good frame sets both
// motor commands from the tilt. All work for an item is one pass of logic between the parser
// state and the output register; a one-entry skid buffer takes one more transfer while a
// result waits, after which input stalls until the output drains. Configuration is to be
// written through cfg_we_i while the block is idle; the block itself does not enforce this.
module tilt_packet_to_drive_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // rx_byte[7:0], distance_mm[23:8], distance_ok[24]
  input  logic [1:0]  s_axis_tuser,   // command[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // drive_update[0], right_drive[2:1], left_drive[4:3],
                                      // frame_accepted[5], checksum_error[6]
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic [31:0] timeout_q;
  logic [15:0] obstacle_q;
  logic [30:0] thresh_q;
  logic [3:0]  pos_q, pos_d;
  logic [95:0] payload_q, payload_d;
  logic [7:0]  sum_q, sum_d;
  logic [31:0] idle_q, idle_d;
  tpd_pkg::result_t res_d, out_q, skid_q;
  logic out_vld_q, skid_vld_q;
  logic in_fire;

  logic [1:0]  cmd;
  logic [7:0]  rx_byte;
  logic [15:0] dist_mm;
  logic        dok;
  logic [31:0] x, y, z, tp, tn;
  logic        xin, yin;
  logic [31:0] idle_inc;

  assign cmd     = s_axis_tuser;
  assign rx_byte = s_axis_tdata[7:0];
  assign dist_mm = s_axis_tdata[23:8];
  assign dok     = s_axis_tdata[24];

  assign s_axis_tready = !skid_vld_q;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  assign x  = payload_q[31:0];
  assign y  = payload_q[63:32];
  assign z  = payload_q[95:64];
  assign tp = {1'b0, thresh_q};
  assign tn = {1'b1, thresh_q};
  assign xin = tpd_pkg::f_le(x, tp) && tpd_pkg::f_le(tn, x);
  assign yin = tpd_pkg::f_le(y, tp) && tpd_pkg::f_le(tn, y);
  assign idle_inc = (idle_q == '1) ? idle_q : idle_q + 32'd1;

  always_comb begin
    pos_d     = pos_q;
    payload_d = payload_q;
    sum_d     = sum_q;
    idle_d    = idle_q;
    res_d     = '0;
    case (cmd)
      tpd_pkg::CmdByte: begin
        idle_d = '0;
        if (pos_q == tpd_pkg::PosStart) begin
          if (rx_byte == tpd_pkg::HdrStart) pos_d = tpd_pkg::PosKind;
        end else if (pos_q == tpd_pkg::PosKind) begin
          if (rx_byte == tpd_pkg::HdrKind) begin
            pos_d = tpd_pkg::PosData;
            sum_d = '0;
          end else begin
            pos_d = tpd_pkg::PosStart;
          end
        end else if (pos_q < tpd_pkg::PosCheck) begin
          payload_d = {rx_byte, payload_q[95:8]};
          sum_d = sum_q + rx_byte;
          pos_d = pos_q + 4'd1;
        end else begin
          if (rx_byte == ~(tpd_pkg::HdrStart + tpd_pkg::HdrKind + sum_q)) begin
            res_d.frame_accepted = 1'b1;
            res_d.drive_update   = 1'b1;
            if (tpd_pkg::f_le(x, tp) && tpd_pkg::f_le(tp, y)) begin
              res_d.right_drive = tpd_pkg::DrvFwd;
              res_d.left_drive  = tpd_pkg::DrvFwd;
            end else if (tpd_pkg::f_le(x, tp) && tpd_pkg::f_le(y, tn)) begin
              res_d.right_drive = tpd_pkg::DrvRev;
              res_d.left_drive  = tpd_pkg::DrvRev;
            end else if (xin && yin && tpd_pkg::f_le(z, tn)) begin
              res_d.right_drive = tpd_pkg::DrvRev;
              res_d.left_drive  = tpd_pkg::DrvFwd;
            end else if (xin && yin && tpd_pkg::f_le(tp, z)) begin
              res_d.right_drive = tpd_pkg::DrvFwd;
              res_d.left_drive  = tpd_pkg::DrvRev;
            end
          end else begin
            res_d.checksum_error = 1'b1;
          end
          pos_d = tpd_pkg::PosStart;
          sum_d = '0;
        end
      end
      tpd_pkg::CmdTick: begin
        idle_d = idle_inc;
        res_d.drive_update = idle_inc > timeout_q;
      end
      tpd_pkg::CmdDist: begin
        if (dok && dist_mm < obstacle_q) begin
          res_d.drive_update = 1'b1;
          pos_d = tpd_pkg::PosStart;
          sum_d = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q  <= tpd_pkg::TimeoutReset;
      obstacle_q <= tpd_pkg::ObstacleReset;
      thresh_q   <= tpd_pkg::ThresholdReset;
      pos_q      <= tpd_pkg::PosStart;
      sum_q      <= '0;
      idle_q     <= '0;
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          tpd_pkg::RegTimeout:   timeout_q  <= cfg_data_i;
          tpd_pkg::RegObstacle:  obstacle_q <= cfg_data_i[15:0];
          tpd_pkg::RegThreshold: thresh_q   <= cfg_data_i[30:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        pos_q  <= pos_d;
        sum_q  <= sum_d;
        idle_q <= idle_d;
      end
      if (!out_vld_q || m_axis_tready) begin
        out_vld_q  <= skid_vld_q || in_fire;
        skid_vld_q <= 1'b0;
      end else if (in_fire) begin
        skid_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) payload_q <= payload_d;
    if (!out_vld_q || m_axis_tready) begin
      out_q <= skid_vld_q ? skid_q : res_d;
    end else if (in_fire) begin
      skid_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {1'b0, out_q};

  `TPD_ASSERT_IMP(a_skid_implies_out, skid_vld_q, out_vld_q, "skid full with empty output")
  `TPD_ASSERT_IMP(a_pos_range, 1'b1, pos_q <= tpd_pkg::PosCheck, "parse position out of range")
  `TPD_ASSERT_NEXT(a_hold_out, m_axis_tvalid && !m_axis_tready, m_axis_tvalid,
                   "result dropped while stalled")
  `TPD_ASSERT_IMP(a_flags_excl, out_vld_q,
                  !(out_q.frame_accepted && out_q.checksum_error), "both frame flags set")

endmodule
